### hw/rtl/pbsr_pkg.sv
`timescale 1ns / 1ps
package pbsr_pkg;
  localparam int FRAC_BITS = 16;
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_BOX   = 2'd2;
  localparam logic [2:0] REG_LEFT   = 3'd0;
  localparam logic [2:0] REG_TOP    = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;
  localparam logic [2:0] REG_EPS    = 3'd4;
  localparam int IN_W  = 232;
  localparam int OUT_W = 144;

  // viewport registers handed to the transform pipe
  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] top;
    logic [30:0]        width;
    logic [30:0]        height;
    logic [15:0]        eps;
  } view_cfg_t;

  // one corner travelling through the transform pipe
  typedef struct packed {
    logic        first;
    logic        last;
    logic        is_box;
    logic        bad;
  } corner_tag_t;

  // per corner result leaving the transform pipe
  typedef struct packed {
    corner_tag_t        tag;
    logic               ok;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [16:0]        dep;
  } corner_res_t;
endpackage

### hw/rtl/pbsr_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider: floor(a*2^fb/b) saturated at 2^(QW-1), one quotient bit per stage
module pbsr_div #(
  parameter int AW = 64,
  parameter int FB = 16,
  parameter int QW = 31,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  input  logic [PW-1:0] pass_in,
  output logic [QW-1:0] q,
  output logic [PW-1:0] pass_out
);
  localparam int NS = QW;
  localparam int SW = AW + FB;
  logic [SW-1:0] n_r [1:NS];
  logic [AW-1:0] d_r [1:NS];
  logic [AW:0]   r_r [1:NS];
  logic [QW-1:0] q_r [1:NS];
  logic          sat_r [1:NS];
  logic [PW-1:0] p_r [1:NS];

  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_st
      logic [SW-1:0] n_i;
      logic [AW-1:0] d_i;
      logic [AW:0]   r_i;
      logic [QW-1:0] q_i;
      logic          sat_i;
      logic [PW-1:0] p_i;
      logic [AW:0]   t;
      if (g == 0) begin : g_head
        always_comb begin
          n_i = {a, {FB{1'b0}}};
          d_i = b;
          // numerator bits above the quotient width seed the remainder
          r_i = (AW+1)'(n_i >> QW);
          q_i = '0;
          // integer part too large for the quotient width saturates
          sat_i = ((a >> (QW - 1 - FB)) >= b);
          p_i = pass_in;
        end
      end else begin : g_body
        always_comb begin
          n_i = n_r[g];
          d_i = d_r[g];
          r_i = r_r[g];
          q_i = q_r[g];
          sat_i = sat_r[g];
          p_i = p_r[g];
        end
      end
      always_comb t = {r_i[AW-1:0], n_i[QW-1-g]};
      always_ff @(posedge clk) begin
        if (en) begin
          if (t >= {1'b0, d_i}) begin
            r_r[g+1] <= t - {1'b0, d_i};
            q_r[g+1] <= {q_i[QW-2:0], 1'b1};
          end else begin
            r_r[g+1] <= t;
            q_r[g+1] <= {q_i[QW-2:0], 1'b0};
          end
          n_r[g+1] <= n_i;
          d_r[g+1] <= d_i;
          sat_r[g+1] <= sat_i;
          p_r[g+1] <= p_i;
        end
      end
    end
  endgenerate

  assign q = sat_r[NS] ? QW'(1) << (QW - 1) : q_r[NS];
  assign pass_out = p_r[NS];
endmodule

### hw/rtl/pbsr_xform.sv
`timescale 1ns / 1ps
module pbsr_xform #(
  parameter int FB = pbsr_pkg::FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_v,
  input  pbsr_pkg::corner_tag_t  in_tag,
  input  logic signed [31:0]     px,
  input  logic signed [31:0]     py,
  input  logic signed [31:0]     pz,
  input  logic [31:0]            coef [0:15],
  input  pbsr_pkg::view_cfg_t    cfg,
  output logic                   out_v,
  output pbsr_pkg::corner_res_t  out_res
);
  localparam int QW = 31;
  localparam int PW = 4 + 1 + 1 + 1;
  localparam int LAT = 3 + QW + 2;
  logic signed [63:0] prod_r [0:15];
  logic signed [63:0] clip_r [0:3];
  logic signed [63:0] w2_r, cz2_r;
  logic [63:0] aw_r, ax_r, ay_r, az_r;
  logic nsx_r, nsy_r, good_r;
  pbsr_pkg::corner_tag_t tg_r [0:2];
  logic [LAT-1:0] vpipe_r;
  logic signed [63:0] vv [0:3];

  always_comb begin
    vv[0] = 64'(px); vv[1] = 64'(py); vv[2] = 64'(pz);
    vv[3] = 64'sd1 <<< FB;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 16; i++)
        prod_r[i] <= (64'($signed(coef[i])) * vv[i % 4]) >>> FB;
      tg_r[0] <= in_tag;
      for (int r = 0; r < 4; r++)
        clip_r[r] <= prod_r[4*r] + prod_r[4*r+1] + prod_r[4*r+2] + prod_r[4*r+3];
      tg_r[1] <= tg_r[0];
      aw_r <= clip_r[3][63] ? 64'(-clip_r[3]) : 64'(clip_r[3]);
      ax_r <= clip_r[0][63] ? 64'(-clip_r[0]) : 64'(clip_r[0]);
      ay_r <= clip_r[1][63] ? 64'(-clip_r[1]) : 64'(clip_r[1]);
      az_r <= clip_r[2][63] ? 64'(-clip_r[2]) : 64'(clip_r[2]);
      nsx_r <= clip_r[0][63] ^ clip_r[3][63];
      nsy_r <= clip_r[1][63] ^ clip_r[3][63];
      w2_r <= clip_r[3]; cz2_r <= clip_r[2];
      tg_r[2] <= tg_r[1];
      good_r <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vpipe_r <= '0;
    else if (en) vpipe_r <= {vpipe_r[LAT-2:0], in_v};
  end

  // accept test from stage three values
  logic ok3;
  always_comb begin
    ok3 = (aw_r > 64'(cfg.eps));
    if (!w2_r[63]) begin
      if (cz2_r < 0 || cz2_r > w2_r) ok3 = 1'b0;
    end else begin
      if (cz2_r > 0 || cz2_r < w2_r) ok3 = 1'b0;
    end
    if (!good_r) ok3 = 1'b0;
  end

  logic [QW-1:0] qx, qy, qz;
  logic [PW-1:0] px_o, py_o, pz_o;
  logic [PW-1:0] pin;
  assign pin = {tg_r[2], ok3, nsx_r, nsy_r};
  pbsr_div #(.AW(64), .FB(FB), .QW(QW), .PW(PW)) u_dx (
    .clk(clk), .en(en), .a(ax_r), .b(aw_r), .pass_in(pin), .q(qx), .pass_out(px_o));
  pbsr_div #(.AW(64), .FB(FB), .QW(QW), .PW(PW)) u_dy (
    .clk(clk), .en(en), .a(ay_r), .b(aw_r), .pass_in(pin), .q(qy), .pass_out(py_o));
  // depth is Q1.16 and at most 1.0 once accepted
  pbsr_div #(.AW(64), .FB(16), .QW(QW), .PW(PW)) u_dz (
    .clk(clk), .en(en), .a(az_r), .b(aw_r), .pass_in(pin), .q(qz), .pass_out(pz_o));

  // capped magnitudes, signed ndc
  logic signed [32:0] nx_r, ny_r;
  logic [16:0] dz_r;
  pbsr_pkg::corner_tag_t tg4_r;
  logic ok4_r;
  logic [QW-1:0] capx, capy;
  always_comb begin
    capx = (qx > (QW'(1) << 30)) ? (QW'(1) << 30) : qx;
    capy = (qy > (QW'(1) << 30)) ? (QW'(1) << 30) : qy;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nx_r <= px_o[1] ? -$signed({2'b00, capx}) : $signed({2'b00, capx});
      ny_r <= px_o[0] ? -$signed({2'b00, capy}) : $signed({2'b00, capy});
      dz_r <= (qz > 31'd65536) ? 17'd65536 : qz[16:0];
      tg4_r <= px_o[PW-1:3];
      ok4_r <= px_o[2];
    end
  end
  logic signed [33:0] fx, fy;
  logic signed [66:0] mx_r, my_r;
  logic [16:0] dz5_r;
  pbsr_pkg::corner_tag_t tg5_r;
  logic ok5_r;
  always_comb begin
    fx = 34'(nx_r) + (34'sd1 <<< FB);
    fy = (34'sd1 <<< FB) - 34'(ny_r);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= (67'(fx) * 67'($signed({1'b0, cfg.width}))) >>> (FB + 1);
      my_r <= (67'(fy) * 67'($signed({1'b0, cfg.height}))) >>> (FB + 1);
      dz5_r <= dz_r; tg5_r <= tg4_r; ok5_r <= ok4_r;
    end
  end
  logic signed [66:0] sx, sy;
  always_comb begin
    sx = mx_r + 67'(cfg.left);
    sy = my_r + 67'(cfg.top);
    out_res.tag = tg5_r;
    out_res.ok  = ok5_r;
    out_res.sx  = (sx > 67'sd2147483647) ? 32'sh7fffffff :
                  (sx < -67'sd2147483648) ? 32'sh80000000 : sx[31:0];
    out_res.sy  = (sy > 67'sd2147483647) ? 32'sh7fffffff :
                  (sy < -67'sd2147483648) ? 32'sh80000000 : sy[31:0];
    out_res.dep = dz5_r;
  end
  assign out_v = vpipe_r[LAT-1];
  logic unused;
  assign unused = ^{pz_o, py_o};
endmodule

### hw/rtl/pbsr_merge.sv
`timescale 1ns / 1ps
// folds corner results into one response per request
module pbsr_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_v,
  input  pbsr_pkg::corner_res_t in_res,
  output logic                  out_v,
  output logic [143:0]          out_data
);
  logic any_r, v_r;
  logic signed [31:0] mnx_r, mny_r, mxx_r, mxy_r;
  logic [143:0] d_r;
  logic any_n;
  logic signed [31:0] mnx_n, mny_n, mxx_n, mxy_n;
  logic signed [32:0] dw, dh;
  logic [30:0] sw, sh;

  always_comb begin
    any_n = in_res.tag.first ? 1'b0 : any_r;
    mnx_n = mnx_r; mny_n = mny_r; mxx_n = mxx_r; mxy_n = mxy_r;
    if (in_res.ok) begin
      if (!any_n) begin
        mnx_n = in_res.sx; mxx_n = in_res.sx; mny_n = in_res.sy; mxy_n = in_res.sy;
      end else begin
        if (in_res.sx < mnx_n) mnx_n = in_res.sx;
        if (in_res.sx > mxx_n) mxx_n = in_res.sx;
        if (in_res.sy < mny_n) mny_n = in_res.sy;
        if (in_res.sy > mxy_n) mxy_n = in_res.sy;
      end
      any_n = 1'b1;
    end
    dw = 33'(mxx_n) - 33'(mnx_n);
    dh = 33'(mxy_n) - 33'(mny_n);
    sw = dw[32:31] != 2'b00 ? 31'h7fffffff : dw[30:0];
    sh = dh[32:31] != 2'b00 ? 31'h7fffffff : dh[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r <= 1'b0; v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v && in_res.tag.last;
      if (in_v) any_r <= any_n;
    end
  end
  always_ff @(posedge clk) begin
    if (en && in_v) begin
      mnx_r <= mnx_n; mny_r <= mny_n; mxx_r <= mxx_n; mxy_r <= mxy_n;
      if (in_res.tag.bad)
        d_r <= {{143{1'b0}}, !in_res.tag.first};
      else if (in_res.tag.is_box)
        d_r <= any_n ? {17'd0, sh, sw, mny_n, mnx_n, 1'b0} : {143'd0, 1'b1};
      else
        d_r <= in_res.ok ? {in_res.dep, 62'd0, in_res.sy, in_res.sx, 1'b0}
                         : {143'd0, 1'b1};
    end
  end
  assign out_v = v_r;
  assign out_data = d_r;
endmodule

### hw/rtl/project_box_to_screen_rect.sv
`timescale 1ns / 1ps
// perspective projection of points and boxes into a viewport rectangle
// in_: requests (op, coef_index, coef_value, box corners, box_valid) on tdata
// out_: one response per request (status, pos_x, pos_y, size_w, size_h, depth)
// cfg_: apb registers at 0x0 left, 0x4 top, 0x8 width, 0xc height, 0x10 w epsilon
// loads and points are taken as one input transfer, a valid box is held for eight
// corners, as the single transform and divide pipe takes one corner per cycle while
// the output is not stalled; on its way to the response a corner passes three
// transform stages, the 31 stage quotient pipe, two scaling stages and the
// response register
// reset clears the matrix to zero and the registers to their defaults
// a stalled receiver stops the whole pipe; nothing is lost or repeated
// one response register sits on the output; the pipe advances whenever it
// is empty or being drained
module project_box_to_screen_rect #(
  parameter int FRAC_BITS = pbsr_pkg::FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op, coef_index, coef_value, min_x, min_y, min_z, max_x, max_y, max_z, box_valid
  input  logic [231:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, pos_x, pos_y, size_w, size_h, depth
  output logic [143:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  logic [31:0] coef_r [0:15];
  pbsr_pkg::view_cfg_t cfg_r;
  logic en;
  logic [2:0] cnt_r;
  logic [1:0] op;
  logic mv, fv;
  pbsr_pkg::corner_res_t mres;
  logic ov_r;
  logic [143:0] od_r;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{left: '0, top: '0, width: '0, height: '0, eps: 16'd7};
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[4:2])
        pbsr_pkg::REG_LEFT:   cfg_r.left   <= cfg_pwdata;
        pbsr_pkg::REG_TOP:    cfg_r.top    <= cfg_pwdata;
        pbsr_pkg::REG_WIDTH:  cfg_r.width  <= cfg_pwdata[30:0];
        pbsr_pkg::REG_HEIGHT: cfg_r.height <= cfg_pwdata[30:0];
        pbsr_pkg::REG_EPS:    cfg_r.eps    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (cfg_paddr[4:2])
      pbsr_pkg::REG_LEFT:   cfg_prdata = cfg_r.left;
      pbsr_pkg::REG_TOP:    cfg_prdata = cfg_r.top;
      pbsr_pkg::REG_WIDTH:  cfg_prdata = {1'b0, cfg_r.width};
      pbsr_pkg::REG_HEIGHT: cfg_prdata = {1'b0, cfg_r.height};
      pbsr_pkg::REG_EPS:    cfg_prdata = {16'd0, cfg_r.eps};
      default:              cfg_prdata = '0;
    endcase
  end

  assign en = !ov_r || out_tready;
  assign op = in_tdata[1:0];
  logic is_box;
  assign is_box = (op == pbsr_pkg::OP_BOX) && in_tdata[230];
  // a valid box holds the request for eight corners
  assign in_tready = en && (!is_box || cnt_r == 3'd7);
  assign fv = in_tvalid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (fv && is_box) cnt_r <= cnt_r + 3'd1;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) coef_r[i] <= '0;
    end else if (in_tvalid && in_tready && op == pbsr_pkg::OP_LOAD) begin
      coef_r[in_tdata[5:2]] <= in_tdata[37:6];
    end
  end

  logic xs, ys, zs;
  pbsr_pkg::corner_tag_t tag;
  always_comb begin
    xs = is_box && (cnt_r[1:0] == 2'd1 || cnt_r[1:0] == 2'd2);
    ys = is_box && cnt_r[1];
    zs = is_box && cnt_r[2];
    tag.first  = (op == pbsr_pkg::OP_LOAD);
    tag.last   = !is_box || cnt_r == 3'd7;
    tag.is_box = is_box;
    tag.bad    = !(op == pbsr_pkg::OP_POINT || is_box);
  end

  pbsr_pkg::corner_tag_t tg;
  assign tg = '{first: tag.bad ? tag.first : (!is_box || cnt_r == 3'd0),
                last: tag.last, is_box: tag.is_box, bad: tag.bad};

  pbsr_xform #(.FB(FRAC_BITS)) u_xf (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(fv), .in_tag(tg),
    .px(xs ? in_tdata[165:134] : in_tdata[69:38]),
    .py(ys ? in_tdata[197:166] : in_tdata[101:70]),
    .pz(zs ? in_tdata[229:198] : in_tdata[133:102]),
    .coef(coef_r), .cfg(cfg_r), .out_v(mv), .out_res(mres));
  pbsr_merge u_mg (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(mv), .in_res(mres),
    .out_v(ov_r), .out_data(od_r));

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  logic unused;
  assign unused = in_tdata[231];
endmodule

### hw/rtl/pbsr_check.sv
`timescale 1ns / 1ps
module pbsr_check (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata,
  input logic         cfg_pready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("response changed while stalled");
  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[143:1] == '0)
    else $error("rejected response carries data");
  a_dep: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[143:127] <= 17'd65536)
    else $error("depth above one");
  a_rdy: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");
endmodule

bind project_box_to_screen_rect pbsr_check u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .cfg_pready(cfg_pready));

### dv/project_box_to_screen_rect_test.sv
`timescale 1ns / 1ps
module project_box_to_screen_rect_test;

  typedef struct packed {
    logic        box_valid;
    logic [31:0] max_z, max_y, max_x, min_z, min_y, min_x;
    logic [31:0] coef_value;
    logic [3:0]  coef_index;
    logic [1:0]  op;
  } request_t;

  typedef struct {
    bit                 status;
    logic signed [31:0] pos_x, pos_y;
    logic [30:0]        size_w, size_h;
    logic [16:0]        depth;
  } screen_res_t;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam longint ONE = longint'(1) << pbsr_pkg::FRAC_BITS;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  // op, coef_index, coef_value, min_x, min_y, min_z, max_x, max_y, max_z, box_valid, pad
  logic [231:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  // status, pos_x, pos_y, size_w, size_h, depth
  logic [143:0] out_tdata;
  logic         cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  project_box_to_screen_rect uut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic [31:0] matrix [16];
  logic signed [31:0] vp_left, vp_top;
  logic [30:0] vp_width, vp_height;
  logic [15:0] vp_eps;

  screen_res_t screen_q[$];
  int errors = 0;
  int idle_pct = 0, stall_pct = 0, hold_left = 0;
  int n_loads = 0, n_points = 0, n_boxes = 0, n_rejects = 0, n_checked = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  function automatic longint unsigned frac_quot(longint unsigned a, longint unsigned b,
                                                int fb, longint unsigned cap);
    longint unsigned qi, r, f;
    qi = a / b;
    r = a % b;
    f = 0;
    if (qi >= (cap >> fb)) return cap;
    for (int i = 0; i < fb; i++) begin
      r = r << 1;
      f = f << 1;
      if (r >= b) begin
        r -= b;
        f |= 1;
      end
    end
    qi = (qi << fb) | f;
    return (qi > cap) ? cap : qi;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint ndc_of(longint num, longint w);
    longint m;
    m = longint'(frac_quot(num < 0 ? -num : num, w < 0 ? -w : w, pbsr_pkg::FRAC_BITS,
                           longint'(1) << 30));
    return ((num < 0) != (w < 0)) ? -m : m;
  endfunction

  function automatic bit project_point(longint px, longint py, longint pz,
                                       output longint sx, output longint sy,
                                       output longint unsigned dep);
    longint v[4], clip[4], w, cz, aw, nx, ny;
    v[0] = px; v[1] = py; v[2] = pz; v[3] = ONE;
    sx = 0; sy = 0; dep = 0;
    for (int r = 0; r < 4; r++) begin
      clip[r] = 0;
      for (int c = 0; c < 4; c++)
        clip[r] += (longint'($signed(matrix[r*4+c])) * v[c]) >>> pbsr_pkg::FRAC_BITS;
    end
    w = clip[3];
    cz = clip[2];
    aw = w < 0 ? -w : w;
    if (aw <= longint'(vp_eps)) return 0;
    if (w > 0) begin
      if (cz < 0 || cz > w) return 0;
    end else begin
      if (cz > 0 || cz < w) return 0;
    end
    dep = frac_quot(cz < 0 ? -cz : cz, aw, 16, 64'd65536);
    nx = ndc_of(clip[0], w);
    ny = ndc_of(clip[1], w);
    sx = sat32(longint'(vp_left) +
               (((nx + ONE) * longint'(vp_width)) >>> (pbsr_pkg::FRAC_BITS + 1)));
    sy = sat32(longint'(vp_top) +
               (((ONE - ny) * longint'(vp_height)) >>> (pbsr_pkg::FRAC_BITS + 1)));
    return 1;
  endfunction

  function automatic screen_res_t predict_response(request_t rq);
    screen_res_t res;
    longint sx, sy, mnx, mny, mxx, mxy, lo[3], hi[3];
    longint unsigned dep;
    bit any;
    res = '{1, 0, 0, 0, 0, 0};
    lo[0] = $signed(rq.min_x); lo[1] = $signed(rq.min_y); lo[2] = $signed(rq.min_z);
    hi[0] = $signed(rq.max_x); hi[1] = $signed(rq.max_y); hi[2] = $signed(rq.max_z);
    any = 0;
    mnx = 0; mny = 0; mxx = 0; mxy = 0;
    case (rq.op)
      pbsr_pkg::OP_LOAD: begin
        matrix[rq.coef_index] = rq.coef_value;
        res.status = 0;
      end
      pbsr_pkg::OP_POINT: begin
        if (project_point(lo[0], lo[1], lo[2], sx, sy, dep)) begin
          res.status = 0;
          res.pos_x = sx[31:0];
          res.pos_y = sy[31:0];
          res.depth = dep[16:0];
        end
      end
      pbsr_pkg::OP_BOX: begin
        if (rq.box_valid) begin
          for (int k = 0; k < 8; k++) begin
            // x takes the high bound on corners 1,2,5,6; y on 2,3,6,7; z on 4..7
            if (!project_point(((k & 3) == 1 || (k & 3) == 2) ? hi[0] : lo[0],
                               ((k & 3) >= 2) ? hi[1] : lo[1],
                               (k >= 4) ? hi[2] : lo[2], sx, sy, dep))
              continue;
            if (!any) begin
              mnx = sx; mxx = sx; mny = sy; mxy = sy;
              any = 1;
            end else begin
              if (sx < mnx) mnx = sx;
              if (sx > mxx) mxx = sx;
              if (sy < mny) mny = sy;
              if (sy > mxy) mxy = sy;
            end
          end
          if (any) begin
            res.status = 0;
            res.pos_x = mnx[31:0];
            res.pos_y = mny[31:0];
            res.size_w = 31'(sat32(mxx - mnx));
            res.size_h = 31'(sat32(mxy - mny));
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // response checker
  always @(posedge clk) begin
    screen_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (screen_q.size() == 0) begin
        report_mismatch("unexpected response, status", out_tdata[0], -1);
      end else begin
        want = screen_q.pop_front();
        n_checked++;
        if (out_tdata[0] !== want.status) report_mismatch("status", out_tdata[0], want.status);
        if (out_tdata[32:1] !== want.pos_x)
          report_mismatch("pos_x", $signed(out_tdata[32:1]), want.pos_x);
        if (out_tdata[64:33] !== want.pos_y)
          report_mismatch("pos_y", $signed(out_tdata[64:33]), want.pos_y);
        if (out_tdata[95:65] !== want.size_w)
          report_mismatch("size_w", out_tdata[95:65], want.size_w);
        if (out_tdata[126:96] !== want.size_h)
          report_mismatch("size_h", out_tdata[126:96], want.size_h);
        if (out_tdata[143:127] !== want.depth)
          report_mismatch("depth", out_tdata[143:127], want.depth);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_request(input request_t rq);
    screen_res_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, rq};
    do @(posedge clk); while (!in_tready);
    res = predict_response(rq);
    screen_q.push_back(res);
    case (rq.op)
      pbsr_pkg::OP_LOAD: n_loads++;
      pbsr_pkg::OP_POINT: n_points++;
      pbsr_pkg::OP_BOX: n_boxes++;
      default: ;
    endcase
    if (rq.op != pbsr_pkg::OP_LOAD && res.status) n_rejects++;
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    end_burst();
    while (screen_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      pbsr_pkg::REG_LEFT: vp_left = val;
      pbsr_pkg::REG_TOP: vp_top = val;
      pbsr_pkg::REG_WIDTH: vp_width = val[30:0];
      pbsr_pkg::REG_HEIGHT: vp_height = val[30:0];
      pbsr_pkg::REG_EPS: vp_eps = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_viewport(input logic [31:0] l, t, w, h, e);
    write_reg(pbsr_pkg::REG_LEFT, l);
    write_reg(pbsr_pkg::REG_TOP, t);
    write_reg(pbsr_pkg::REG_WIDTH, w);
    write_reg(pbsr_pkg::REG_HEIGHT, h);
    write_reg(pbsr_pkg::REG_EPS, e);
  endtask

  function automatic request_t make_load(int idx, logic [31:0] val);
    request_t rq;
    rq = request_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    rq.op = pbsr_pkg::OP_LOAD;
    rq.coef_index = idx[3:0];
    rq.coef_value = val;
    return rq;
  endfunction

  function automatic logic [31:0] small_signed(int lim);
    return 32'($signed($urandom_range(2 * lim)) - lim);
  endfunction

  // perspective-like matrix: w follows +/-z, clip z a fraction of it
  task automatic load_camera(input bit noisy);
    logic [31:0] m [16];
    int sgn;
    sgn = $urandom_range(1) ? 1 : -1;
    foreach (m[i]) m[i] = noisy && $urandom_range(3) == 0 ? $urandom : 32'd0;
    m[0] = small_signed(4 << 16);
    m[3] = small_signed(8 << 16);
    m[5] = small_signed(4 << 16);
    m[7] = small_signed(8 << 16);
    m[10] = 32'(sgn * int'($urandom_range(65536)));
    m[11] = small_signed(1 << 15);
    m[14] = 32'(sgn * 65536);
    foreach (m[i]) send_request(make_load(i, m[i]));
  endtask

  function automatic request_t make_geometry();
    request_t rq;
    int z0;
    rq = request_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    rq.op = ($urandom_range(1)) ? pbsr_pkg::OP_POINT : pbsr_pkg::OP_BOX;
    rq.box_valid = ($urandom_range(15) != 0);
    if ($urandom_range(9) < 8) begin
      z0 = $urandom_range(1 << 16, 60 << 16);
      rq.min_x = small_signed(50 << 16);
      rq.min_y = small_signed(50 << 16);
      rq.min_z = $urandom_range(9) == 0 ? small_signed(5 << 16) : 32'(z0);
      rq.max_x = rq.min_x + $urandom_range(20 << 16);
      rq.max_y = rq.min_y + $urandom_range(20 << 16);
      rq.max_z = z0 + $urandom_range(20 << 16);
    end
    if ($urandom_range(19) == 0) rq.op = OP_SPARE;
    return rq;
  endfunction

  task automatic test_directed();
    request_t rq;
    set_viewport(32'd0, 32'd0, 32'(1920 << 16), 32'(1080 << 16), 32'd7);
    // all-zero matrix: w of zero fails the epsilon test
    rq = make_load(0, 0);
    rq.op = pbsr_pkg::OP_POINT; rq.min_x = 0; rq.min_y = 0; rq.min_z = 0;
    send_request(rq);
    send_request(make_load(0, 32'h0001_0000));
    send_request(make_load(5, 32'h0001_0000));
    send_request(make_load(10, 32'h0000_8000));
    send_request(make_load(14, 32'h0001_0000));
    send_request(make_load(15, 32'h8000_0000));
    send_request(make_load(15, 32'h7fff_ffff));
    send_request(make_load(15, 32'h0000_0000));
    // centre point, point behind camera, point with w exactly at epsilon
    rq.min_x = 0; rq.min_y = 0; rq.min_z = 32'(10 << 16);
    send_request(rq);
    rq.min_z = 32'hfff6_0000;
    send_request(rq);
    rq.min_z = 32'd7;
    send_request(rq);
    rq.min_z = 32'd8;
    send_request(rq);
    // extreme coordinates saturate the ndc and the screen position
    rq.min_x = 32'h7fff_ffff; rq.min_y = 32'h8000_0000; rq.min_z = 32'd65536;
    send_request(rq);
    rq.min_x = 32'h8000_0000; rq.min_y = 32'h7fff_ffff;
    send_request(rq);
    // boxes: valid, invalid, all behind camera, straddling, reversed bounds
    rq.op = pbsr_pkg::OP_BOX; rq.box_valid = 1;
    rq.min_x = 32'hfffb_0000; rq.min_y = 32'hfffb_0000; rq.min_z = 32'(5 << 16);
    rq.max_x = 32'(5 << 16); rq.max_y = 32'(5 << 16); rq.max_z = 32'(9 << 16);
    send_request(rq);
    rq.box_valid = 0;
    send_request(rq);
    rq.box_valid = 1; rq.min_z = 32'hfff0_0000; rq.max_z = 32'hfff8_0000;
    send_request(rq);
    rq.max_z = 32'(3 << 16);
    send_request(rq);
    rq.min_z = 32'(9 << 16); rq.max_z = 32'(5 << 16); rq.max_x = 32'h8000_0000;
    send_request(rq);
    rq.min_x = 32'h8000_0000; rq.max_x = 32'h7fff_ffff; rq.min_y = 32'h8000_0000;
    rq.max_y = 32'h7fff_ffff;
    send_request(rq);
    rq.op = OP_SPARE;
    send_request(rq);
    drain();
  endtask

  task automatic test_random_phase(input int count, idle, stall, input bit noisy);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if (i % 48 == 0) load_camera(noisy);
      else if ($urandom_range(19) == 0)
        send_request(make_load($urandom_range(15), $urandom));
      else send_request(make_geometry());
    end
    drain();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 10;
    hold_left = 400;
    load_camera(0);
    for (int i = 0; i < 80; i++) send_request(make_geometry());
    drain();
  endtask

  task automatic test_pause();
    idle_pct = 20;
    stall_pct = 30;
    load_camera(0);
    for (int i = 0; i < 30; i++) send_request(make_geometry());
    end_burst();
    while (screen_q.size() != 0) @(posedge clk);
    for (int i = 0; i < 30; i++) send_request(make_geometry());
    drain();
  endtask

  initial begin
    foreach (matrix[i]) matrix[i] = '0;
    vp_left = 0; vp_top = 0; vp_width = 0; vp_height = 0; vp_eps = 16'd7;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(220, 0, 0, 0);
    set_viewport(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0);
    test_random_phase(220, 75, 0, 1);
    set_viewport($urandom, $urandom, $urandom, $urandom, 32'd65535);
    test_random_phase(220, 0, 75, 0);
    set_viewport(32'(100 << 16), 32'(50 << 16), 32'd0, 32'd0, 32'd7);
    test_random_phase(150, 18, 18, 1);
    set_viewport(32'(100 << 16), 32'(50 << 16), 32'(640 << 16), 32'(480 << 16), 32'd7);
    test_backpressure();
    test_pause();
    $display("covered %0d loads, %0d points, %0d boxes; %0d rejected, %0d responses checked",
             n_loads, n_points, n_boxes, n_rejects, n_checked);
    $display("viewport extremes, idle and stall mixes, a long output hold-off and a drained pause");
    if (errors == 0 && screen_q.size() == 0) begin
      $display("project_box_to_screen_rect verification clean");
    end else begin
      $display("project_box_to_screen_rect verification failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("project_box_to_screen_rect verification failed");
    $finish;
  end
endmodule

### sim.f
hw/rtl/pbsr_pkg.sv
hw/rtl/pbsr_div.sv
hw/rtl/pbsr_xform.sv
hw/rtl/pbsr_merge.sv
hw/rtl/project_box_to_screen_rect.sv
hw/rtl/pbsr_check.sv
dv/project_box_to_screen_rect_test.sv
